@@ design/sslp_pkg.sv @@
// Package: constants, codes and helper functions of the servo slew limiter.
`timescale 1ns / 1ps
`default_nettype none
package sslp_pkg;

	localparam int NUM_JOINTS       = 3;
	localparam int ANGLE_W          = 13;
	localparam int TARGET_W         = 14;
	localparam int TICK_W           = 12;
	localparam int CFG_W            = 8;
	localparam int COUNT_W          = 4;
	localparam int ANGLE_FULL_SCALE = 4320;

	// Fixed-point pulse mapping: (a * TICK_MUL + TICK_OFS + TICK_RND) >> 16
	localparam int PROD_W   = 28;
	localparam int TICK_SH  = 16;
	localparam logic [PROD_W-1:0] TICK_MUL = PROD_W'(6214);
	localparam logic [PROD_W-1:0] TICK_OFS = PROD_W'(6710886);
	localparam logic [PROD_W-1:0] TICK_RND = PROD_W'(32768);

	localparam logic [ANGLE_W-1:0] PARK_ANGLE [NUM_JOINTS] = '{
		ANGLE_W'(2880), ANGLE_W'(2160), ANGLE_W'(2160)
	};

	localparam logic [CFG_W-1:0] STEP_SIZE_RESET      = CFG_W'(32);
	localparam logic [CFG_W-1:0] SNAP_THRESHOLD_RESET = CFG_W'(16);

	typedef enum logic {
		OP_SET  = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic {
		REG_STEP_SIZE      = 1'b0,
		REG_SNAP_THRESHOLD = 1'b1
	} cfg_reg_t;

	typedef logic [ANGLE_W-1:0]  angle_t;
	typedef logic [TARGET_W-1:0] target_t;
	typedef logic [TICK_W-1:0]   tick_t;

	// Clamp a signed 14-bit angle to 0..ANGLE_FULL_SCALE.
	function automatic angle_t clamp_angle(input logic signed [TARGET_W-1:0] a);
		angle_t r;
		if (a < 0) begin
			r = '0;
		end else if (a > TARGET_W'(ANGLE_FULL_SCALE)) begin
			r = ANGLE_W'(ANGLE_FULL_SCALE);
		end else begin
			r = a[ANGLE_W-1:0];
		end
		return r;
	endfunction

	// Map an angle to its 12-bit PWM off tick, rounding half up.
	function automatic tick_t angle_tick(input angle_t a);
		logic [PROD_W-1:0] sum;
		sum = PROD_W'(a) * TICK_MUL + TICK_OFS + TICK_RND;
		return sum[TICK_SH +: TICK_W];
	endfunction

endpackage
`default_nettype wire

@@ design/servo_slew_limiter_pwm_top.sv @@
// Top level: three-joint servo slew limiter with PWM tick outputs.
`timescale 1ns / 1ps
`default_nettype none
//
// Channel   Direction  Handshake            Payload
// --------  ---------  -------------------  ----------------------------------------
// input     in         in_valid / in_stall  op, cmd_count, target_0..target_2
// output    out        out_valid/out_stall  tick_0..tick_2, angle_0..angle_2
// config    in         cfg_we               cfg_index, cfg_data (8 bit)
//
// One item per cycle while in_stall is low. An item is held in the input register, where the
// slew step, clamp and tick multiply run per joint; a tick item then lands in the result
// register, which drives out_valid.
// Set items with cmd_count of at least NUM_JOINTS update the targets; no set item leaves a result.
// Reset (arst_n low) restores the home angles and the default step and threshold.
// A stall on the output backs up into in_stall only when a tick item waits
// behind a full result register.
module servo_slew_limiter_pwm_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [sslp_pkg::CFG_W-1:0]  cfg_data,
	// input channel
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        op,
	input  wire logic [sslp_pkg::COUNT_W-1:0] cmd_count,
	input  wire logic [sslp_pkg::TARGET_W-1:0] target_0,
	input  wire logic [sslp_pkg::TARGET_W-1:0] target_1,
	input  wire logic [sslp_pkg::TARGET_W-1:0] target_2,
	// output channel
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [sslp_pkg::TICK_W-1:0]      tick_0,
	output logic [sslp_pkg::TICK_W-1:0]      tick_1,
	output logic [sslp_pkg::TICK_W-1:0]      tick_2,
	output logic [sslp_pkg::ANGLE_W-1:0]     angle_0,
	output logic [sslp_pkg::ANGLE_W-1:0]     angle_1,
	output logic [sslp_pkg::ANGLE_W-1:0]     angle_2
);
	import sslp_pkg::*;

	// configuration registers
	logic [CFG_W-1:0] step_size_q;
	logic [CFG_W-1:0] snap_threshold_q;

	// joint state
	angle_t tgt_q [NUM_JOINTS];
	angle_t cur_q [NUM_JOINTS];

	// input register
	logic             valid_s1;
	op_t              op_s1;
	logic [COUNT_W-1:0] count_s1;
	target_t          target_s1 [NUM_JOINTS];

	// result register
	logic             valid_s2;
	tick_t            tick_s2  [NUM_JOINTS];
	angle_t           angle_s2 [NUM_JOINTS];

	// handshake
	logic out_free;
	logic adv_s1;
	logic in_fire;
	logic tick_fire;
	logic set_fire;

	// per-joint next values
	angle_t next_cur [NUM_JOINTS];
	tick_t  next_tick [NUM_JOINTS];

	assign out_free  = !valid_s2 || !out_stall;
	// A set item never needs the result register, so it always drains.
	assign adv_s1    = !valid_s1 || (op_s1 == OP_SET) || out_free;
	assign in_stall  = !adv_s1;
	assign in_fire   = in_valid && adv_s1;
	assign tick_fire = valid_s1 && (op_s1 == OP_TICK) && out_free;
	assign set_fire  = valid_s1 && (op_s1 == OP_SET) && (count_s1 >= COUNT_W'(NUM_JOINTS));

	// Slew step per joint: snap when close, else step toward target, then clamp.
	always_comb begin
		for (int j = 0; j < NUM_JOINTS; j++) begin
			logic signed [TARGET_W-1:0] diff;
			logic        [ANGLE_W-1:0]  mag;
			logic signed [TARGET_W-1:0] moved;
			diff = $signed({1'b0, tgt_q[j]}) - $signed({1'b0, cur_q[j]});
			mag  = diff[TARGET_W-1] ? ANGLE_W'(-diff) : diff[ANGLE_W-1:0];
			if (diff > 0) begin
				moved = $signed({1'b0, cur_q[j]}) + $signed(TARGET_W'(step_size_q));
			end else begin
				moved = $signed({1'b0, cur_q[j]}) - $signed(TARGET_W'(step_size_q));
			end
			if (mag > ANGLE_W'(snap_threshold_q)) begin
				next_cur[j] = clamp_angle(moved);
			end else begin
				next_cur[j] = tgt_q[j];
			end
			next_tick[j] = angle_tick(next_cur[j]);
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q      <= STEP_SIZE_RESET;
			snap_threshold_q <= SNAP_THRESHOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_STEP_SIZE:      step_size_q      <= cfg_data;
				REG_SNAP_THRESHOLD: snap_threshold_q <= cfg_data;
				default:            ;
			endcase
		end
	end

	// joint state: targets on a full set item, current angles on a tick item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_JOINTS; j++) begin
				tgt_q[j] <= PARK_ANGLE[j];
				cur_q[j] <= PARK_ANGLE[j];
			end
		end else begin
			for (int j = 0; j < NUM_JOINTS; j++) begin
				if (set_fire) begin
					tgt_q[j] <= clamp_angle(target_s1[j]);
				end
				if (tick_fire) begin
					cur_q[j] <= next_cur[j];
				end
			end
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload: load on accept only
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1        <= op_t'(op);
			count_s1     <= cmd_count;
			target_s1[0] <= target_0;
			target_s1[1] <= target_1;
			target_s1[2] <= target_2;
		end
	end

	// result register control: load on a tick, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (tick_fire) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_fire) begin
			for (int j = 0; j < NUM_JOINTS; j++) begin
				tick_s2[j]  <= next_tick[j];
				angle_s2[j] <= next_cur[j];
			end
		end
	end

	assign out_valid = valid_s2;
	assign tick_0    = tick_s2[0];
	assign tick_1    = tick_s2[1];
	assign tick_2    = tick_s2[2];
	assign angle_0   = angle_s2[0];
	assign angle_1   = angle_s2[1];
	assign angle_2   = angle_s2[2];

	// A stall on the input only comes from a tick item blocked by a held result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && op_s1 == OP_TICK && valid_s2 && out_stall))
		else $error("input stalled without a blocked tick item");

	// A set item leaves the result register alone.
	a_set_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && op_s1 == OP_SET && !valid_s2) |=> !valid_s2)
		else $error("set item produced a result");

	// Current angles never leave the legal range.
	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q[0] <= ANGLE_W'(ANGLE_FULL_SCALE) && cur_q[1] <= ANGLE_W'(ANGLE_FULL_SCALE)
		&& cur_q[2] <= ANGLE_W'(ANGLE_FULL_SCALE))
		else $error("current angle out of range");

	// Targets never leave the legal range.
	a_tgt_range: assert property (@(posedge clk) disable iff (!arst_n)
		tgt_q[0] <= ANGLE_W'(ANGLE_FULL_SCALE) && tgt_q[1] <= ANGLE_W'(ANGLE_FULL_SCALE)
		&& tgt_q[2] <= ANGLE_W'(ANGLE_FULL_SCALE))
		else $error("target angle out of range");

	// A published result matches the current state of joint 0.
	a_result_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		tick_fire |=> (valid_s2 && angle_s2[0] == cur_q[0]))
		else $error("result does not match current angle");

endmodule
`default_nettype wire

@@ tb/servo_pose_checker.sv @@
`timescale 1ns / 1ps
// Checker: predicts joint poses from accepted items and compares each result item.
module servo_pose_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [sslp_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          op,
	input  logic [sslp_pkg::COUNT_W-1:0]  cmd_count,
	input  logic [sslp_pkg::TARGET_W-1:0] target_0,
	input  logic [sslp_pkg::TARGET_W-1:0] target_1,
	input  logic [sslp_pkg::TARGET_W-1:0] target_2,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [sslp_pkg::TICK_W-1:0]   tick_0,
	input  logic [sslp_pkg::TICK_W-1:0]   tick_1,
	input  logic [sslp_pkg::TICK_W-1:0]   tick_2,
	input  logic [sslp_pkg::ANGLE_W-1:0]  angle_0,
	input  logic [sslp_pkg::ANGLE_W-1:0]  angle_1,
	input  logic [sslp_pkg::ANGLE_W-1:0]  angle_2,
	output int                            fail_count,
	output int                            pending
);
	import sslp_pkg::*;

	typedef struct packed {
		tick_t  [NUM_JOINTS-1:0] tick;
		angle_t [NUM_JOINTS-1:0] angle;
	} pose_t;

	logic [CFG_W-1:0] step_size;
	logic [CFG_W-1:0] snap_threshold;
	angle_t           goal_angle [NUM_JOINTS];
	angle_t           cur_angle [NUM_JOINTS];
	target_t          cmd_target [NUM_JOINTS];
	pose_t            pose_q [$];
	pose_t            seen_pose;

	assign cmd_target[0] = target_0;
	assign cmd_target[1] = target_1;
	assign cmd_target[2] = target_2;
	assign seen_pose     = {tick_2, tick_1, tick_0, angle_2, angle_1, angle_0};

	initial fail_count = 0;
	initial pending    = 0;

	function automatic angle_t limit_angle(input int a);
		if (a < 0) begin
			return '0;
		end
		if (a > ANGLE_FULL_SCALE) begin
			return angle_t'(ANGLE_FULL_SCALE);
		end
		return angle_t'(a);
	endfunction

	// 500..2500 us pulse over the full angle range, rounded half up
	function automatic tick_t pwm_tick(input angle_t a);
		int acc;
		acc = int'(a) * 6214 + 6710886 + 32768;
		return tick_t'(acc >> 16);
	endfunction

	task automatic log_failure(input string what);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%s", what);
		end
	endtask

	task automatic apply_command();
		int    diff;
		int    mag;
		int    stride;
		pose_t next;
		if (op_t'(op) == OP_SET) begin
			// short commands are dropped without touching the targets
			if (int'(cmd_count) >= NUM_JOINTS) begin
				for (int j = 0; j < NUM_JOINTS; j++) begin
					goal_angle[j] = limit_angle(int'($signed(cmd_target[j])));
				end
			end
		end else begin
			for (int j = 0; j < NUM_JOINTS; j++) begin
				diff = int'(goal_angle[j]) - int'(cur_angle[j]);
				mag  = (diff < 0) ? -diff : diff;
				if (mag > int'(snap_threshold)) begin
					stride       = (diff > 0) ? int'(step_size) : -int'(step_size);
					cur_angle[j] = limit_angle(int'(cur_angle[j]) + stride);
				end else begin
					cur_angle[j] = goal_angle[j];
				end
				next.tick[j]  = pwm_tick(cur_angle[j]);
				next.angle[j] = cur_angle[j];
			end
			pose_q.push_back(next);
		end
	endtask

	task automatic check_pose();
		pose_t want;
		if (pose_q.size() == 0) begin
			log_failure($sformatf("%0t: result item with none expected", $realtime));
		end else begin
			want = pose_q.pop_front();
			for (int j = 0; j < NUM_JOINTS; j++) begin
				if (seen_pose.tick[j] !== want.tick[j]) begin
					log_failure($sformatf("%0t: tick_%0d expected %0d, got %0d",
						$realtime, j, want.tick[j], seen_pose.tick[j]));
				end
				if (seen_pose.angle[j] !== want.angle[j]) begin
					log_failure($sformatf("%0t: angle_%0d expected %0d, got %0d",
						$realtime, j, want.angle[j], seen_pose.angle[j]));
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size      = STEP_SIZE_RESET;
			snap_threshold = SNAP_THRESHOLD_RESET;
			for (int j = 0; j < NUM_JOINTS; j++) begin
				goal_angle[j] = PARK_ANGLE[j];
				cur_angle[j]  = PARK_ANGLE[j];
			end
			pose_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_STEP_SIZE: begin
						step_size = cfg_data;
					end
					REG_SNAP_THRESHOLD: begin
						snap_threshold = cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (out_valid && !out_stall) begin
				check_pose();
			end
			if (in_valid && !in_stall) begin
				apply_command();
			end
		end
		pending = pose_q.size();
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Testbench top: clock, reset, stimulus phases and verdict for the servo slew limiter.
module tb;
	import sslp_pkg::*;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int PHASES         = 6;
	localparam int PHASE_ITEMS    = 320;
	localparam int PRESSURE_PHASE = 4;
	localparam int HOLD_CYCLES    = 300;
	// input and result register of the pipeline plus margin for a set item still in flight
	localparam int SETTLE_CYCLES  = 4;
	localparam int MAX_GAP        = 40;

	// idle and stall chances in percent, one entry per random phase
	localparam int IDLE_PCT [PHASES]  = '{0, 86, 0, 12, 0, 12};
	localparam int STALL_PCT [PHASES] = '{0, 0, 86, 12, 0, 12};

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic                cfg_index = 1'b0;
	logic [CFG_W-1:0]    cfg_data  = '0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic                op        = 1'b0;
	logic [COUNT_W-1:0]  cmd_count = '0;
	logic [TARGET_W-1:0] target_0  = '0;
	logic [TARGET_W-1:0] target_1  = '0;
	logic [TARGET_W-1:0] target_2  = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [TICK_W-1:0]   tick_0;
	logic [TICK_W-1:0]   tick_1;
	logic [TICK_W-1:0]   tick_2;
	logic [ANGLE_W-1:0]  angle_0;
	logic [ANGLE_W-1:0]  angle_1;
	logic [ANGLE_W-1:0]  angle_2;

	int fail_count;
	int pending;
	int cycle_count = 0;
	int idle_pct    = 0;
	int stall_pct   = 0;
	bit pressure_on = 1'b0;

	always #5 clk = ~clk;

	servo_slew_limiter_pwm_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.cmd_count (cmd_count),
		.target_0  (target_0),
		.target_1  (target_1),
		.target_2  (target_2),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.tick_0    (tick_0),
		.tick_1    (tick_1),
		.tick_2    (tick_2),
		.angle_0   (angle_0),
		.angle_1   (angle_1),
		.angle_2   (angle_2)
	);

	// The checker watches both channels and the register port on its own.
	servo_pose_checker pose_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.cmd_count  (cmd_count),
		.target_0   (target_0),
		.target_1   (target_1),
		.target_2   (target_2),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.tick_0     (tick_0),
		.tick_1     (tick_1),
		.tick_2     (tick_2),
		.angle_0    (angle_0),
		.angle_1    (angle_1),
		.angle_2    (angle_2),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver side: random stalls per phase, plus one long hold-off in the
	// pressure phase so that tick items back up and the block stalls its input.
	initial begin : receiver
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (pressure_on && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Offer one item after a random gap; return at the edge that accepts it.
	task automatic send_item(input op_t o, input logic [COUNT_W-1:0] cnt,
			input target_t t0, input target_t t1, input target_t t2);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
			gap++;
		end
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= o;
		cmd_count <= cnt;
		target_0  <= t0;
		target_1  <= t1;
		target_2  <= t2;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
	endtask

	// Drop valid, wait for every expected result, then let the pipe run dry.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) begin
			@(posedge clk);
		end
	endtask

	// Write both registers on back-to-back cycles; only while idle.
	task automatic set_config(input logic [CFG_W-1:0] step, input logic [CFG_W-1:0] thr);
		cfg_we    <= 1'b1;
		cfg_index <= REG_STEP_SIZE;
		cfg_data  <= step;
		@(posedge clk);
		cfg_index <= REG_SNAP_THRESHOLD;
		cfg_data  <= thr;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Mostly legal angles, some raw 14-bit noise, some extremes.
	function automatic target_t rand_target();
		int r;
		r = $urandom_range(99);
		if (r < 65) begin
			return target_t'($urandom_range(ANGLE_FULL_SCALE));
		end
		if (r < 85) begin
			return target_t'($urandom);
		end
		if (r < 92) begin
			return $urandom_range(1) ? target_t'(ANGLE_FULL_SCALE) : '0;
		end
		case ($urandom_range(3))
			0: return {1'b1, {(TARGET_W-1){1'b0}}};
			1: return {1'b0, {(TARGET_W-1){1'b1}}};
			2: return target_t'(ANGLE_FULL_SCALE + 1);
			default: return '1;
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] rand_reg();
		case ($urandom_range(5))
			0: return '0;
			1: return CFG_W'(1);
			2: return '1;
			default: return CFG_W'($urandom_range(1, 255));
		endcase
	endfunction

	// Runs of ticks between target updates, with some short commands mixed in.
	task automatic rand_item();
		logic [COUNT_W-1:0] cnt;
		if ($urandom_range(99) < 70) begin
			send_item(OP_TICK, COUNT_W'($urandom), target_t'($urandom),
				target_t'($urandom), target_t'($urandom));
		end else begin
			if ($urandom_range(99) < 85) begin
				cnt = COUNT_W'($urandom_range(NUM_JOINTS, 15));
			end else begin
				cnt = COUNT_W'($urandom_range(NUM_JOINTS - 1));
			end
			send_item(OP_SET, cnt, rand_target(), rand_target(), rand_target());
		end
	endtask

	initial begin : stimulus
		int ph;
		int n;
		repeat (11) begin
			@(posedge clk);
		end
		arst_n <= 1'b1;
		@(posedge clk);

		// home pose, then a short command that must be dropped
		send_item(OP_TICK, '0, '0, '0, '0);
		send_item(OP_SET, COUNT_W'(2), '0, '0, '0);
		send_item(OP_TICK, '0, '0, '0, '0);
		// most negative, most positive and just above full scale
		send_item(OP_SET, COUNT_W'(3), target_t'(-8192), target_t'(8191),
			target_t'(ANGLE_FULL_SCALE + 1));
		send_item(OP_TICK, '0, '0, '0, '0);
		send_item(OP_TICK, '0, '0, '0, '0);
		send_item(OP_SET, '1, target_t'(ANGLE_FULL_SCALE), '0, target_t'(-1));
		send_item(OP_TICK, '0, '0, '0, '0);
		// tick with junk in the fields it ignores
		send_item(OP_TICK, '1, '1, target_t'(14'h1555), target_t'(14'h2aaa));
		drain();

		// zero step: far joints freeze, the joint on target stays put
		set_config('0, '0);
		send_item(OP_SET, COUNT_W'(3), target_t'(100), target_t'(4000), target_t'(2160));
		send_item(OP_TICK, '0, '0, '0, '0);
		send_item(OP_TICK, '0, '0, '0, '0);
		drain();

		// largest step with no snap window: overshoot around the target
		set_config('1, '0);
		send_item(OP_TICK, '0, '0, '0, '0);
		send_item(OP_TICK, '0, '0, '0, '0);
		send_item(OP_TICK, '0, '0, '0, '0);
		drain();

		// widest snap window
		set_config('1, '1);
		send_item(OP_TICK, '0, '0, '0, '0);
		drain();

		// overshoot then snap back on the next tick
		set_config(CFG_W'(200), CFG_W'(100));
		send_item(OP_SET, COUNT_W'(4), target_t'(1000), target_t'(2010), target_t'(2300));
		for (n = 0; n < 8; n++) begin
			send_item(OP_TICK, '0, '0, '0, '0);
		end

		for (ph = 0; ph < PHASES; ph++) begin
			drain();
			set_config(rand_reg(), rand_reg());
			idle_pct    = IDLE_PCT[ph];
			stall_pct   = STALL_PCT[ph];
			pressure_on = (ph == PRESSURE_PHASE);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				rand_item();
			end
		end
		drain();

		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
